>>> hw/rtl/first_fit_heap_allocator_macros.svh
// Assertion macros used by the allocator RTL (ffha_ctrl).
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FFHA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    localparam int POOL_BYTES_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int SIZE_W = 10;
    localparam int OFF_W  = 10;

    typedef enum logic
    {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_ZERO   = 2'd2,
        ST_BADOFF = 2'd3
    } status_t;

    typedef struct packed
    {
        logic             valid;
        status_t          status;
        logic [OFF_W-1:0] payload_offset;
    } res_t;

endpackage

>>> hw/rtl/ffha_if.sv
// Request and response channel interfaces of the allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [ffha_pkg::SIZE_W-1:0]   request_size;
    logic [ffha_pkg::OFF_W-1:0]    release_offset;

    modport source (output valid, output command, output request_size,
                    output release_offset, input ready);
    modport sink   (input valid, input command, input request_size,
                    input release_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [ffha_pkg::OFF_W-1:0]    payload_offset;

    modport source (output valid, output status, output payload_offset, input ready);
    modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

>>> hw/rtl/first_fit_heap_allocator.sv
// Accepting an item issues the first header read; the walk then visits block
// headers in address order (the next header's address is the sum of the header
// just read, which feeds the single header memory's read port), then an optional
// split or merge write-back state and a result state hand the result to the
// output register; a zero-size request skips the walk. No clearing pass after
// reset; the first beat may be accepted right away. One beat in flight at a
// time; a finished result waits in the output register while the next request is taken.
module first_fit_heap_allocator #(
    parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ffha_req_if.sink   req_ch,
    ffha_rsp_if.source rsp_ch
);

    localparam int AW = $clog2(POOL_BYTES);

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_rsize;
    logic          mem_rfree;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_wsize;
    logic          mem_wfree;

    ffha_pkg::res_t res;
    logic           res_ready;

    logic                       rsp_valid_reg;
    logic [1:0]                 rsp_status_reg;
    logic [ffha_pkg::OFF_W-1:0] rsp_offset_reg;

    assign res_ready = !rsp_valid_reg || rsp_ch.ready;

    ffha_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req_ch.valid),
        .in_ready       (req_ch.ready),
        .command        (ffha_pkg::cmd_t'(req_ch.command)),
        .request_size   (req_ch.request_size),
        .release_offset (req_ch.release_offset),
        .res            (res),
        .res_ready      (res_ready),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rsize      (mem_rsize),
        .mem_rfree      (mem_rfree),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wsize      (mem_wsize),
        .mem_wfree      (mem_wfree)
    );

    ffha_mem #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_size (mem_rsize),
        .rd_free (mem_rfree),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_size (mem_wsize),
        .wr_free (mem_wfree)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            rsp_status_reg <= res.status;
            rsp_offset_reg <= res.payload_offset;
        end
    end

    assign rsp_ch.valid          = rsp_valid_reg;
    assign rsp_ch.status         = rsp_status_reg;
    assign rsp_ch.payload_offset = rsp_offset_reg;

endmodule

>>> hw/rtl/ffha_mem.sv
// Block header memory: payload size and free flag per pool offset.
// Registered read; entry zero reads as the whole free pool until first written.
module ffha_mem #(
    parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    localparam int AW          = $clog2(POOL_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_size,
    output logic          rd_free,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_size,
    input  logic          wr_free
);

    localparam logic [AW-1:0] INIT_SIZE = AW'(POOL_BYTES - HEADER_BYTES);

    logic [AW:0] mem_arr [POOL_BYTES];
    logic [AW:0] rd_q_reg;
    logic        rd_zero_reg;
    logic        zero_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_arr[wr_addr] <= {wr_free, wr_size};
        end
        if (rd_en)
        begin
            rd_q_reg <= mem_arr[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_addr == '0)
            begin
                zero_valid_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_zero_reg <= (rd_addr == '0);
            end
        end
    end

    always_comb
    begin
        if (rd_zero_reg && !zero_valid_reg)
        begin
            rd_free = 1'b1;
            rd_size = INIT_SIZE;
        end
        else
        begin
            rd_free = rd_q_reg[AW];
            rd_size = rd_q_reg[AW-1:0];
        end
    end

endmodule

>>> hw/rtl/ffha_ctrl.sv
// Walk sequencer: visits block headers in address order, one read per cycle,
// and writes back split, allocate and merge results. Depends on ffha_pkg.
`include "first_fit_heap_allocator_macros.svh"

module ffha_ctrl #(
    parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    localparam int AW          = $clog2(POOL_BYTES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffha_pkg::cmd_t              command,
    input  logic [ffha_pkg::SIZE_W-1:0] request_size,
    input  logic [ffha_pkg::OFF_W-1:0]  release_offset,
    output ffha_pkg::res_t              res,
    input  logic                        res_ready,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [AW-1:0]               mem_rsize,
    input  logic                        mem_rfree,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [AW-1:0]               mem_wsize,
    output logic                        mem_wfree
);

    localparam int CW = (AW + 1 > ffha_pkg::SIZE_W + 1) ? AW + 1 : ffha_pkg::SIZE_W + 1;
    localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] POOL = CW'(POOL_BYTES);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_WALK,
        S_MERGE,
        S_SPLIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   has_prev_reg, has_prev_next;

    ffha_pkg::cmd_t              cmd_reg, cmd_next;
    logic [ffha_pkg::SIZE_W-1:0] req_reg, req_next;
    logic [ffha_pkg::OFF_W-1:0]  target_reg, target_next;
    logic [CW-1:0]               off_reg, off_next;
    logic [AW-1:0]               prev_off_reg, prev_off_next;
    logic [AW-1:0]               prev_size_reg, prev_size_next;
    logic                        prev_free_reg, prev_free_next;
    logic [AW-1:0]               cur_off_reg, cur_off_next;
    logic [AW-1:0]               cur_size_reg, cur_size_next;
    logic [AW-1:0]               split_off_reg, split_off_next;
    logic [AW-1:0]               split_size_reg, split_size_next;
    ffha_pkg::status_t           status_reg, status_next;
    logic [ffha_pkg::OFF_W-1:0]  pay_reg, pay_next;

    logic [CW-1:0] need;
    logic [CW-1:0] blk_size;
    logic [CW-1:0] nxt;
    logic [CW-1:0] split_at;
    logic          fit;
    logic          hit;
    logic          at_end;

    assign need     = CW'(req_reg) + HDR;
    assign blk_size = CW'(mem_rsize);
    assign nxt      = off_reg + HDR + blk_size;
    assign split_at = off_reg + need;
    assign fit      = mem_rfree && (blk_size >= need);
    assign hit      = (off_reg + HDR) == CW'(target_reg);
    assign at_end   = nxt >= POOL;

    assign in_ready           = (state_reg == S_IDLE);
    assign res.valid          = (state_reg == S_RESULT);
    assign res.status         = status_reg;
    assign res.payload_offset = pay_reg;

    always_comb
    begin
        state_next      = state_reg;
        has_prev_next   = has_prev_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        target_next     = target_reg;
        off_next        = off_reg;
        prev_off_next   = prev_off_reg;
        prev_size_next  = prev_size_reg;
        prev_free_next  = prev_free_reg;
        cur_off_next    = cur_off_reg;
        cur_size_next   = cur_size_reg;
        split_off_next  = split_off_reg;
        split_size_next = split_size_reg;
        status_next     = status_reg;
        pay_next        = pay_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wsize       = '0;
        mem_wfree       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = command;
                    req_next      = request_size;
                    target_next   = release_offset;
                    off_next      = '0;
                    has_prev_next = 1'b0;
                    pay_next      = '0;
                    if (command == ffha_pkg::CMD_ALLOC && request_size == '0)
                    begin
                        status_next = ffha_pkg::ST_ZERO;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (cmd_reg == ffha_pkg::CMD_ALLOC && fit)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = AW'(off_reg);
                    mem_wfree   = 1'b0;
                    mem_wsize   = (blk_size > need) ? AW'(req_reg) : mem_rsize;
                    status_next = ffha_pkg::ST_OK;
                    pay_next    = ffha_pkg::OFF_W'(off_reg + HDR);
                    if (blk_size > need && split_at < POOL)
                    begin
                        split_off_next  = AW'(split_at);
                        split_size_next = AW'(blk_size - need);
                        state_next      = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (cmd_reg == ffha_pkg::CMD_RELEASE && hit)
                begin
                    status_next = ffha_pkg::ST_OK;
                    pay_next    = '0;
                    if (has_prev_reg && prev_free_reg)
                    begin
                        cur_off_next  = prev_off_reg;
                        cur_size_next = AW'(CW'(prev_size_reg) + HDR + blk_size);
                    end
                    else
                    begin
                        cur_off_next  = AW'(off_reg);
                        cur_size_next = mem_rsize;
                    end
                    if (!at_end)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(nxt);
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = cur_off_next;
                        mem_wsize  = cur_size_next;
                        mem_wfree  = 1'b1;
                        state_next = S_RESULT;
                    end
                end
                else if (at_end)
                begin
                    status_next = (cmd_reg == ffha_pkg::CMD_ALLOC) ?
                                  ffha_pkg::ST_NOFIT : ffha_pkg::ST_BADOFF;
                    pay_next    = '0;
                    state_next  = S_RESULT;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(nxt);
                    off_next       = nxt;
                    prev_off_next  = AW'(off_reg);
                    prev_size_next = mem_rsize;
                    prev_free_next = mem_rfree;
                    has_prev_next  = 1'b1;
                end
            end

            S_MERGE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_off_reg;
                mem_wfree  = 1'b1;
                mem_wsize  = mem_rfree ? AW'(CW'(cur_size_reg) + HDR + blk_size)
                                       : cur_size_reg;
                state_next = S_RESULT;
            end

            S_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = split_off_reg;
                mem_wsize  = split_size_reg;
                mem_wfree  = 1'b1;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            has_prev_reg <= 1'b0;
            status_reg   <= ffha_pkg::ST_OK;
            pay_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            has_prev_reg <= has_prev_next;
            status_reg   <= status_next;
            pay_reg      <= pay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        req_reg        <= req_next;
        target_reg     <= target_next;
        off_reg        <= off_next;
        prev_off_reg   <= prev_off_next;
        prev_size_reg  <= prev_size_next;
        prev_free_reg  <= prev_free_next;
        cur_off_reg    <= cur_off_next;
        cur_size_reg   <= cur_size_next;
        split_off_reg  <= split_off_next;
        split_size_reg <= split_size_next;
    end

    `FFHA_ASSERT_IMPL(a_walk_in_pool, state_reg == S_WALK, off_reg < POOL, "walk left the pool")
    `FFHA_ASSERT_IMPL(a_fail_no_offset, res.valid && res.status != ffha_pkg::ST_OK, res.payload_offset == '0, "failed beat carries an offset")
    `FFHA_ASSERT_IMPL(a_split_after_alloc, state_reg == S_SPLIT, $past(mem_we), "split without allocate write")
    `FFHA_ASSERT_NEXT(a_release_walks, in_valid && in_ready && command == ffha_pkg::CMD_RELEASE, state_reg == S_WALK, "release skipped the walk")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for first_fit_heap_allocator: directed and random alloc/release beats,
// checked against a first-fit heap predictor over the same pool, under four idling phases.
// Depends on ffha_pkg, ffha_if.sv and the allocator RTL.
module tb_top;
    import ffha_pkg::*;

    localparam int POOL        = POOL_BYTES_DEF;
    localparam int HDR         = HEADER_BYTES_DEF;
    localparam int GEN_COPY    = 0;
    localparam int CHECK_COPY  = 1;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASE_ITEMS = 225;

    typedef struct packed
    {
        cmd_t              command;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  release_offset;
    } alloc_req_t;

    typedef struct packed
    {
        status_t          status;
        logic [OFF_W-1:0] payload_offset;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    ffha_req_if req_ch();
    ffha_rsp_if rsp_ch();

    first_fit_heap_allocator u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    always #10 clk = ~clk;

    // two heap images: one steers stimulus, one predicts at accept
    logic [SIZE_W-1:0] blk_size [2][POOL];
    bit                blk_free [2][POOL];

    alloc_req_t     pending_reqs[$];
    alloc_rsp_t     expected_rsp[$];
    logic [OFF_W-1:0] live_offsets[$];
    logic [OFF_W-1:0] freed_offsets[$];

    int sender_idle_pct;
    int recv_stall_pct;
    int items_queued;
    int rsp_seen;
    int fault_count;
    int quiet_cycles;

    function automatic void heap_clear(input int c);
        for (int i = 0; i < POOL; i++)
        begin
            blk_size[c][i] = '0;
            blk_free[c][i] = 1'b0;
        end
        blk_size[c][0] = SIZE_W'(POOL - HDR);
        blk_free[c][0] = 1'b1;
    endfunction

    function automatic alloc_rsp_t heap_step(input int c, input alloc_req_t r);
        alloc_rsp_t rsp;
        int off;
        int prev;
        int nxt;
        int cur;
        int sz;
        int need;
        bit has_prev;
        rsp.status = ST_OK;
        rsp.payload_offset = '0;
        off = 0;
        prev = 0;
        has_prev = 1'b0;
        if (r.command == CMD_ALLOC)
        begin
            need = int'(r.request_size) + HDR;
            if (r.request_size == '0)
            begin
                rsp.status = ST_ZERO;
                return rsp;
            end
            while (off < POOL)
            begin
                sz = int'(blk_size[c][off]);
                if (blk_free[c][off] && sz >= need)
                begin
                    blk_free[c][off] = 1'b0;
                    if (sz > need)
                    begin
                        if (off + need < POOL)
                        begin
                            blk_size[c][off + need] = SIZE_W'(sz - need);
                            blk_free[c][off + need] = 1'b1;
                        end
                        blk_size[c][off] = r.request_size;
                    end
                    rsp.payload_offset = OFF_W'(off + HDR);
                    return rsp;
                end
                off = off + HDR + sz;
            end
            rsp.status = ST_NOFIT;
            return rsp;
        end
        while (off < POOL)
        begin
            nxt = off + HDR + int'(blk_size[c][off]);
            if (off + HDR == int'(r.release_offset))
            begin
                cur = off;
                blk_free[c][cur] = 1'b1;
                if (has_prev && blk_free[c][prev])
                begin
                    blk_size[c][prev] = SIZE_W'(int'(blk_size[c][prev]) + HDR
                                                + int'(blk_size[c][cur]));
                    cur = prev;
                end
                nxt = cur + HDR + int'(blk_size[c][cur]);
                if (nxt < POOL && blk_free[c][nxt])
                    blk_size[c][cur] = SIZE_W'(int'(blk_size[c][cur]) + HDR
                                               + int'(blk_size[c][nxt]));
                return rsp;
            end
            prev = off;
            has_prev = 1'b1;
            off = nxt;
        end
        rsp.status = ST_BADOFF;
        return rsp;
    endfunction

    // value goes to the field the command uses; the other field gets junk
    task automatic queue_item(input cmd_t c, input int value);
        alloc_req_t r;
        alloc_rsp_t rsp;
        r.command = c;
        r.request_size = SIZE_W'($urandom);
        r.release_offset = OFF_W'($urandom);
        if (c == CMD_ALLOC)
            r.request_size = SIZE_W'(value);
        else
            r.release_offset = OFF_W'(value);
        rsp = heap_step(GEN_COPY, r);
        if (rsp.status == ST_OK && c == CMD_ALLOC)
            live_offsets.push_back(rsp.payload_offset);
        if (rsp.status == ST_OK && c == CMD_RELEASE)
        begin
            for (int i = live_offsets.size() - 1; i >= 0; i--)
                if (live_offsets[i] == r.release_offset)
                    live_offsets.delete(i);
            freed_offsets.push_back(r.release_offset);
            if (freed_offsets.size() > 16)
                void'(freed_offsets.pop_front());
        end
        pending_reqs.push_back(r);
        items_queued++;
    endtask

    task automatic queue_random_item();
        int roll;
        int pick;
        int sz;
        roll = $urandom_range(99, 0);
        if (roll < 50 || (roll < 88 && live_offsets.size() == 0))
        begin
            pick = $urandom_range(99, 0);
            if (pick < 3)
                sz = 0;
            else if (pick < 70)
                sz = $urandom_range(48, 1);
            else if (pick < 92)
                sz = $urandom_range(250, 49);
            else
                sz = $urandom_range(1023, 0);
            queue_item(CMD_ALLOC, sz);
        end
        else if (roll < 88)
            queue_item(CMD_RELEASE, live_offsets[$urandom_range(live_offsets.size() - 1, 0)]);
        else if (roll < 94 || freed_offsets.size() == 0)
            queue_item(CMD_RELEASE, $urandom_range(1023, 0));
        else
            queue_item(CMD_RELEASE, freed_offsets[$urandom_range(freed_offsets.size() - 1, 0)]);
    endtask

    task automatic wait_drained();
        while (rsp_seen != items_queued)
            @(posedge clk);
    endtask

    task automatic note_fault(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= 10)
            $display("beat %0d: %s expected %0d got %0d", rsp_seen, what, want, got);
    endtask

    // driver: predicts at accept, then loads the next beat
    always @(posedge clk or negedge rst_n)
    begin
        alloc_req_t seen;
        alloc_req_t nxt_item;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= CMD_ALLOC;
            req_ch.request_size <= '0;
            req_ch.release_offset <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.command = cmd_t'(req_ch.command);
                seen.request_size = req_ch.request_size;
                seen.release_offset = req_ch.release_offset;
                expected_rsp.push_back(heap_step(CHECK_COPY, seen));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    nxt_item = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.command <= nxt_item.command;
                    req_ch.request_size <= nxt_item.request_size;
                    req_ch.release_offset <= nxt_item.release_offset;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        alloc_rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (expected_rsp.size() == 0)
                    note_fault("unexpected beat, status", -1, int'(rsp_ch.status));
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.status !== want.status)
                        note_fault("status", int'(want.status), int'(rsp_ch.status));
                    if (rsp_ch.payload_offset !== want.payload_offset)
                        note_fault("payload_offset", int'(want.payload_offset),
                                   int'(rsp_ch.payload_offset));
                end
            end
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        items_queued = 0;
        heap_clear(GEN_COPY);
        heap_clear(CHECK_COPY);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero size, no fit, exact fit of the whole pool, full heap
        queue_item(CMD_ALLOC, 0);
        queue_item(CMD_ALLOC, 1023);
        queue_item(CMD_ALLOC, 993);
        queue_item(CMD_ALLOC, 992);
        queue_item(CMD_ALLOC, 1);
        // release, release of a free block, unknown offsets
        queue_item(CMD_RELEASE, 16);
        queue_item(CMD_RELEASE, 16);
        queue_item(CMD_RELEASE, 0);
        queue_item(CMD_RELEASE, 1023);
        queue_item(CMD_RELEASE, 5);
        // splits, then merges ahead, behind, and both ways
        queue_item(CMD_ALLOC, 100);
        queue_item(CMD_ALLOC, 200);
        queue_item(CMD_ALLOC, 50);
        queue_item(CMD_ALLOC, 1);
        queue_item(CMD_RELEASE, 132);
        queue_item(CMD_RELEASE, 16);
        queue_item(CMD_RELEASE, 348);
        queue_item(CMD_RELEASE, 414);
        queue_item(CMD_ALLOC, 1008);
        queue_item(CMD_ALLOC, 992);
        queue_item(CMD_RELEASE, 16);

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (PHASE_ITEMS) queue_random_item();
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_count == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
